@@ rtl/sha512t_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sha512t_pkg;

	// One input transaction: eight message bytes with count and last flag.
	typedef struct packed {
		logic [63:0] msg_word;
		logic [3:0]  valid_bytes;
		logic        last_word;
	} in_item_t;

	// One result transaction: a digest word and its position.
	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  digest_index;
		logic        digest_last;
	} out_item_t;

	localparam int unsigned Rounds = 80;

	typedef logic [63:0] chain_arr_t [8];

	localparam chain_arr_t InitChain = '{
		64'h8C3D37C819544DA2, 64'h73E1996689DCD4D6, 64'h1DFAB7AE32FF9C82,
		64'h679DD514582F9FCF, 64'h0F6D2B697BD44DA8, 64'h77E36F7304C48942,
		64'h3F9D85A86A1D36C8, 64'h1112E6AD91D692A1
	};

	// Round constants, one per round.
	function automatic logic [63:0] round_k(input logic [6:0] t);
		logic [63:0] k;
		case (t)
			7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
			7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
			7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
			7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
			7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
			default: k = 64'h0;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

@@ rtl/sha512_224_hash_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Each non-final word is written into the block buffer; the sixteenth word of a block starts
// the 80 rounds and then a chain update on the single shared round unit.
// A last word pads out (one padding word per cycle), compresses one or two blocks,
// then emits four digest words on consecutive cycles; results cannot be stalled.
// Asynchronous active-low reset restores the initial hash and an empty message.
module sha512_224_hash_engine (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire sha512t_pkg::in_item_t in_item,
	output logic                   strobe,
	output sha512t_pkg::out_item_t out_item
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_ROUND, ST_UPDATE, ST_EMIT
	} state_t;

	state_t      state_q;
	logic [63:0] chain_q [8];
	logic [63:0] w_q [16];
	logic [63:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [63:0] bytes_q;
	logic [3:0]  fill_q;
	logic [6:0]  round_q;
	logic        final_q;
	logic        len_q;     // length word still to be written
	logic        mark_q;    // 0x80 marker word still to be written
	logic        defer_q;   // marker sits in slot 14, length goes to next block
	logic [1:0]  emit_q;

	// Last-word masking and marker insertion.
	logic [3:0]  vb;
	logic [63:0] last_data;
	logic [63:0] keep_mask;
	always_comb begin
		vb = (in_item.valid_bytes > 4'd8) ? 4'd8 : in_item.valid_bytes;
		keep_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {vb, 3'b000});
		last_data = (in_item.msg_word & keep_mask) | (64'h80 << {4'd7 - vb[2:0], 3'b000});
	end

	// Shared round unit with message schedule expansion.
	logic [63:0] x15, x2, x7, x16, sg0, sg1, wt, t1, t2;
	logic [3:0]  r4;
	always_comb begin
		r4  = round_q[3:0];
		x15 = w_q[r4 + 4'd1];
		x2  = w_q[r4 + 4'd14];
		x7  = w_q[r4 + 4'd9];
		x16 = w_q[r4];
		sg0 = {x15[0], x15[63:1]} ^ {x15[7:0], x15[63:8]} ^ (x15 >> 7);
		sg1 = {x2[18:0], x2[63:19]} ^ {x2[60:0], x2[63:61]} ^ (x2 >> 6);
		wt  = (round_q < 7'd16) ? x16 : (x16 + sg0 + x7 + sg1);
		t1  = h_q + ({e_q[13:0], e_q[63:14]} ^ {e_q[17:0], e_q[63:18]}
			^ {e_q[40:0], e_q[63:41]}) + ((e_q & f_q) ^ (~e_q & g_q))
			+ sha512t_pkg::round_k(round_q) + wt;
		t2  = ({a_q[27:0], a_q[63:28]} ^ {a_q[33:0], a_q[63:34]} ^ {a_q[38:0], a_q[63:39]})
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	// Word write port: one word into the block buffer per cycle, on an accepted start or while padding.
	logic        wr_en;
	logic [63:0] wr_data;
	always_comb begin
		wr_en = 1'b0;
		wr_data = 64'h0;
		if (state_q == ST_IDLE && start) begin
			wr_en = 1'b1;
			wr_data = in_item.last_word ? ((vb == 4'd8) ? in_item.msg_word : last_data)
				: in_item.msg_word;
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			wr_data = mark_q ? 64'h8000_0000_0000_0000
				: ((len_q && !defer_q && fill_q == 4'd15) ? {bytes_q[60:0], 3'b000}
				: 64'h0);
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Sequencer, block buffer, working variables and digest output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) chain_q[i] <= sha512t_pkg::InitChain[i];
			bytes_q <= 64'h0;
			fill_q  <= 4'd0;
			round_q <= 7'd0;
			final_q <= 1'b0;
			len_q   <= 1'b0;
			mark_q  <= 1'b0;
			defer_q <= 1'b0;
			emit_q  <= 2'd0;
			strobe  <= 1'b0;
			out_item <= '0;
		end else begin
			strobe <= 1'b0;
			if (wr_en) w_q[fill_q] <= wr_data;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						fill_q <= fill_q + 4'd1;
						if (in_item.last_word) begin
							bytes_q <= bytes_q + {60'd0, vb};
							final_q <= 1'b1;
							len_q   <= 1'b1;
							mark_q  <= (vb == 4'd8);
							defer_q <= (fill_q == 4'd14) && (vb != 4'd8);
							state_q <= (fill_q == 4'd15) ? ST_ROUND : ST_PAD;
						end else begin
							bytes_q <= bytes_q + 64'd8;
							if (fill_q == 4'd15) state_q <= ST_ROUND;
						end
						round_q <= 7'd0;
						{a_q, b_q, c_q, d_q} <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3]};
						{e_q, f_q, g_q, h_q} <= {chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 4'd1;
					mark_q <= 1'b0;
					if (fill_q == 4'd15) begin
						// The length only fits when the marker landed before slot 14.
						if (!mark_q && !defer_q) len_q <= 1'b0;
						defer_q <= 1'b0;
						state_q <= ST_ROUND;
					end else if (mark_q && fill_q == 4'd14) begin
						defer_q <= 1'b1;
					end
					round_q <= 7'd0;
					{a_q, b_q, c_q, d_q} <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3]};
					{e_q, f_q, g_q, h_q} <= {chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
				end
				ST_ROUND: begin
					w_q[r4] <= wt;
					h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
					d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
					round_q <= round_q + 7'd1;
					if (round_q == 7'(sha512t_pkg::Rounds - 1)) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					chain_q[0] <= chain_q[0] + a_q; chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q; chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q; chain_q[5] <= chain_q[5] + f_q;
					chain_q[6] <= chain_q[6] + g_q; chain_q[7] <= chain_q[7] + h_q;
					emit_q <= 2'd0;
					if (!final_q) state_q <= ST_IDLE;
					else if (len_q || mark_q) state_q <= ST_PAD;
					else state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe <= 1'b1;
					out_item.digest_word  <= (emit_q == 2'd3)
						? {chain_q[3][63:32], 32'h0} : chain_q[{1'b0, emit_q}];
					out_item.digest_index <= emit_q;
					out_item.digest_last  <= (emit_q == 2'd3);
					emit_q <= emit_q + 2'd1;
					if (emit_q == 2'd3) begin
						state_q <= ST_IDLE;
						for (int i = 0; i < 8; i++) chain_q[i] <= sha512t_pkg::InitChain[i];
						bytes_q <= 64'h0;
						fill_q  <= 4'd0;
						final_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A digest word is only driven while the sequencer is emitting.
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == ST_EMIT)
		else $error("digest strobe outside emit phase");
	// A digest word is flagged last exactly when its index is 3.
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (out_item.digest_last == (out_item.digest_index == 2'd3)))
		else $error("digest_last mismatch");
	// Rounds only run while a block is full.
	a_round_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> fill_q == 4'd0)
		else $error("rounds with partial block");

endmodule
`default_nettype wire

@@ tb/tb_sha512_224_hash_engine.sv @@
`timescale 1ns / 1ps
module tb_sha512_224_hash_engine;

	localparam int unsigned CycleLimit = 600000;
	localparam int unsigned DrainCycles = 200;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sha512t_pkg::in_item_t in_item;
	logic strobe;
	sha512t_pkg::out_item_t out_item;

	sha512_224_hash_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.strobe(strobe),
		.out_item(out_item)
	);

	// Round constants for the digest predictor.
	logic [63:0] sha_k [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	// Predictor state for the message in flight.
	logic [63:0] hash_state [8];
	logic [63:0] msg_block [16];
	logic [63:0] msg_bytes;
	int unsigned block_fill;

	sha512t_pkg::out_item_t digest_q [$];
	int unsigned cycle_count;
	bit failed;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic hash_restart();
		for (int i = 0; i < 8; i++) hash_state[i] = sha512t_pkg::InitChain[i];
		msg_bytes = '0;
		block_fill = 0;
	endtask

	task automatic compress_block();
		logic [63:0] w [80];
		logic [63:0] v [8];
		logic [63:0] t1;
		logic [63:0] t2;
		for (int t = 0; t < 80; t++) begin
			if (t < 16) begin
				w[t] = msg_block[t];
			end else begin
				w[t] = w[t-16] + w[t-7]
					+ (rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7))
					+ (rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6));
			end
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int t = 0; t < 80; t++) begin
			t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k[t] + w[t];
			t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic append_word(input logic [63:0] w);
		msg_block[block_fill] = w;
		block_fill++;
		if (block_fill == 16) begin
			compress_block();
			block_fill = 0;
		end
	endtask

	// Update the digest predictor with one accepted transaction.
	task automatic predict_digest(input sha512t_pkg::in_item_t it);
		logic [63:0] data;
		logic [3:0] nb;
		sha512t_pkg::out_item_t r;
		data = it.msg_word;
		if (!it.last_word) begin
			msg_bytes += 64'd8;
			append_word(data);
			return;
		end
		nb = (it.valid_bytes > 4'd8) ? 4'd8 : it.valid_bytes;
		msg_bytes += 64'(nb);
		if (nb == 0) begin
			append_word(64'h8000000000000000);
		end else if (nb < 8) begin
			data &= ~64'd0 << (64 - 8 * nb);
			data |= 64'h80 << (56 - 8 * nb);
			append_word(data);
		end else begin
			append_word(data);
			append_word(64'h8000000000000000);
		end
		while (block_fill != 14) append_word('0);
		append_word('0);
		append_word(msg_bytes << 3);
		for (int k = 0; k < 4; k++) begin
			r.digest_word = (k == 3) ? (hash_state[k] & 64'hFFFFFFFF00000000) : hash_state[k];
			r.digest_index = 2'(k);
			r.digest_last = (k == 3);
			digest_q.push_back(r);
		end
		hash_restart();
	endtask

	// Send one transaction after a random gap; start stays high into a zero gap.
	task automatic send_word(input logic [63:0] w, input logic [3:0] nb, input logic lst);
		int unsigned gap;
		sha512t_pkg::in_item_t it;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		it.msg_word = w;
		it.valid_bytes = nb;
		it.last_word = lst;
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		predict_digest(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (digest_q.size() != 0) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random message of n full words and a random tail.
	task automatic send_message(input int unsigned n, input logic [3:0] nb);
		for (int i = 0; i < n; i++)
			send_word(rand64(), 4'($urandom_range(0, 15)), 1'b0);
		send_word(rand64(), nb, 1'b1);
	endtask

	task automatic test_directed();
		send_word(64'h0, 4'd0, 1'b1);
		send_word(64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1);
		send_word(64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1);
		send_word(64'h6162630000000000, 4'd3, 1'b1);
		send_word(64'hFFFFFFFFFFFFFFFF, 4'd1, 1'b1);
		send_word(64'hFFFFFFFFFFFFFFFF, 4'd7, 1'b1);
		// Partial count on a non-final word still counts all eight bytes.
		send_word(64'hA5A5A5A5A5A5A5A5, 4'd3, 1'b0);
		send_word(64'h0, 4'd9, 1'b1);
		wait_drained();
	endtask

	task automatic test_block_edges();
		// Tails that fill exactly to the length slot and one past it.
		send_message(13, 4'd8);
		send_message(14, 4'd0);
		send_message(15, 4'd8);
		send_message(16, 4'd5);
		wait_drained();
	endtask

	task automatic test_random();
		int unsigned sent;
		sent = 0;
		while (sent < 230) begin
			automatic int unsigned n = ($urandom_range(0, 7) == 0) ?
				$urandom_range(17, 40) : $urandom_range(0, 16);
			send_message(n, 4'($urandom_range(0, 15)));
			sent += n + 1;
			if ($urandom_range(0, 9) == 0) wait_drained();
		end
	endtask

	// Compare each digest transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (digest_q.size() == 0) begin
				$error("digest transaction with none expected: %h", out_item.digest_word);
				failed = 1'b1;
			end else begin
				automatic sha512t_pkg::out_item_t e = digest_q.pop_front();
				if (out_item.digest_word !== e.digest_word) begin
					$error("digest_word expected %h actual %h", e.digest_word,
						out_item.digest_word);
					failed = 1'b1;
				end
				if (out_item.digest_index !== e.digest_index) begin
					$error("digest_index expected %0d actual %0d", e.digest_index,
						out_item.digest_index);
					failed = 1'b1;
				end
				if (out_item.digest_last !== e.digest_last) begin
					$error("digest_last expected %0d actual %0d", e.digest_last,
						out_item.digest_last);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		failed = 1'b0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		hash_restart();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_block_edges();
		test_random();
		wait_drained();
		repeat (DrainCycles) @(negedge clk);
		if (!failed && digest_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

@@ sha512_224_hash_engine.f @@
rtl/sha512t_pkg.sv
rtl/sha512_224_hash_engine.sv
tb/tb_sha512_224_hash_engine.sv
